// ----- design/rcppm_pkg.sv -----
// Shared types, constants and helpers for the RC pulse-position frame encoder.
// No dependencies; every other file of the block imports this package.
package rcppm_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SLOT_W       = 4;
   localparam int US_W         = 12;
   localparam int TPU_W        = 5;
   localparam int TICKS_W      = 16;
   localparam int REQ_WIDTH_W  = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 12;

   localparam logic [SLOT_W-1:0] NUM_CH_SLOT     = SLOT_W'(NUM_CHANNELS);
   localparam logic [US_W-1:0]   DEFAULT_WIDTH_US = US_W'(1500);

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE        = 3'd0,
      CSR_MIN_WIDTH_US  = 3'd1,
      CSR_MAX_WIDTH_US  = 3'd2,
      CSR_SYNC_WIDTH_US = 3'd3,
      CSR_GAP_US        = 3'd4,
      CSR_TICKS_PER_US  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic              enable;
      logic [US_W-1:0]   min_width_us;
      logic [US_W-1:0]   max_width_us;
      logic [US_W-1:0]   sync_width_us;
      logic [US_W-1:0]   gap_us;
      logic [TPU_W-1:0]  ticks_per_us;
   } cfg_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [SLOT_W-1:0]        channel;
      logic signed [REQ_WIDTH_W-1:0] width_us;
   } req_type;

   typedef struct packed {
      logic              line_level;
      logic [SLOT_W-1:0] slot;
      logic              frame_wrap;
   } seq_status_type;

   typedef struct packed {
      logic              line_level;
      logic [SLOT_W-1:0] slot;
      logic              frame_wrap;
      logic              write_ignored;
   } rsp_type;

   // Microseconds to timer ticks, saturated to the width of the tick counter.
   function automatic logic [TICKS_W-1:0] to_ticks(input logic [US_W-1:0]  us,
                                                   input logic [TPU_W-1:0] tpu);
      logic [US_W+TPU_W-1:0] prod;
      prod = us * tpu;
      if (prod > (US_W+TPU_W)'({TICKS_W{1'b1}}))
         return {TICKS_W{1'b1}};
      else
         return prod[TICKS_W-1:0];
   endfunction

endpackage

// ----- design/rcppm_table.sv -----
// Channel width table: clamps and stores requested widths, reads the width of
// the current slot. Depends on rcppm_pkg.
module rcppm_table import rcppm_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          wr_en,
   input  logic [SLOT_W-1:0]             wr_channel,
   input  logic signed [REQ_WIDTH_W-1:0] wr_width_us,
   input  logic [SLOT_W-1:0]             rd_slot,
   output logic [US_W-1:0]               rd_width_us,
   output logic                          wr_out_of_range
);

   logic [US_W-1:0] width_ff [NUM_CHANNELS];
   logic [US_W-1:0] clamped;
   logic signed [REQ_WIDTH_W:0] w_ext;
   logic signed [REQ_WIDTH_W:0] min_ext;
   logic signed [REQ_WIDTH_W:0] max_ext;

   assign wr_out_of_range = (wr_channel >= NUM_CH_SLOT);

   assign w_ext   = {wr_width_us[REQ_WIDTH_W-1], wr_width_us};
   assign min_ext = (REQ_WIDTH_W+1)'({1'b0, cfg.min_width_us});
   assign max_ext = (REQ_WIDTH_W+1)'({1'b0, cfg.max_width_us});

   // With crossed clamps, a width above the maximum gets the maximum and any other width gets the minimum.
   always_comb begin
      priority if (w_ext > max_ext) begin
         clamped = cfg.max_width_us;
      end else if (w_ext < min_ext) begin
         clamped = cfg.min_width_us;
      end else begin
         clamped = wr_width_us[US_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            width_ff[i] <= DEFAULT_WIDTH_US;
         end
      end else if (wr_en && !wr_out_of_range) begin
         width_ff[wr_channel[CH_IDX_W-1:0]] <= clamped;
      end
   end

   // Slots past the last channel are the sync slot.
   assign rd_width_us = (rd_slot < NUM_CH_SLOT) ? width_ff[rd_slot[CH_IDX_W-1:0]]
                                                : cfg.sync_width_us;

endmodule

// ----- design/rcppm_seq.sv -----
// Frame sequencer: tick counter, slot/gap phase, slot index and line level.
// Depends on rcppm_pkg.
module rcppm_seq import rcppm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              tick_en,
   input  logic [US_W-1:0]   slot_width_us,
   output logic [SLOT_W-1:0] cur_slot,
   output seq_status_type    status
);

   logic [TICKS_W-1:0] remaining_ff, remaining_in;
   logic               in_slot_ff, in_slot_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               line_ff, line_in;
   logic               wrap;

   always_comb begin
      remaining_in = remaining_ff;
      in_slot_in   = in_slot_ff;
      slot_in      = slot_ff;
      line_in      = line_ff;
      wrap         = 1'b0;
      if (tick_en) begin
         priority if (!cfg.enable) begin
            remaining_in = '0;
            in_slot_in   = 1'b0;
            slot_in      = '0;
            line_in      = 1'b0;
         end else if (remaining_ff > TICKS_W'(1)) begin
            remaining_in = remaining_ff - TICKS_W'(1);
         end else if (in_slot_ff) begin
            // Slot over: the gap is high except after the sync slot.
            remaining_in = to_ticks(cfg.gap_us, cfg.ticks_per_us);
            line_in      = (slot_ff < NUM_CH_SLOT);
            in_slot_in   = 1'b0;
            if (slot_ff >= NUM_CH_SLOT) begin
               slot_in = '0;
               wrap    = 1'b1;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end else begin
            remaining_in = to_ticks(slot_width_us, cfg.ticks_per_us);
            line_in      = 1'b0;
            in_slot_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         in_slot_ff   <= 1'b0;
         slot_ff      <= '0;
         line_ff      <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         in_slot_ff   <= in_slot_in;
         slot_ff      <= slot_in;
         line_ff      <= line_in;
      end
   end

   assign cur_slot          = slot_ff;
   assign status.line_level = line_in;
   assign status.slot       = slot_in;
   assign status.frame_wrap = wrap;

endmodule

// ----- design/rc_ppm_frame_encoder.sv -----
// Top level of the RC pulse-position frame encoder: request and response
// registers, configuration registers. Depends on rcppm_pkg, rcppm_table, rcppm_seq.
//
// Usage:
// A request is either a channel width write or one timer tick. Each request
// gives exactly one response with the line level and slot index after it, a
// frame wrap flag and a flag for writes to a channel past the last one.
// A request is taken into an input register; when the output register is free
// or drains, the table and sequencer update and the response is loaded into
// the output register. The response is then on the rsp_ ports and is taken at
// an edge where rsp_stall is low; while the receiver does not stall, one
// request is accepted every cycle.
// When the receiver stalls, the output register holds; the input register still
// accepts one more request, then req_stall is raised until the output moves.
// Reset (synchronous) empties both registers, loads the configuration reset
// values, sets every channel width to 1500 us and parks the line low at slot 0.
// Configuration writes through csr_* take effect at once; the user must make
// them while no request is in flight, as the block itself does not enforce it.
module rc_ppm_frame_encoder import rcppm_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [SLOT_W-1:0]             req_channel,
   input  logic signed [REQ_WIDTH_W-1:0] req_width_us,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_line_level,
   output logic [SLOT_W-1:0]             rsp_slot,
   output logic                          rsp_frame_wrap,
   output logic                          rsp_write_ignored,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   cfg_type        cfg_ff;
   req_type        req_ff;
   logic           req_valid_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff;
   logic           advance;
   logic           tick_en;
   logic           write_en;
   logic [SLOT_W-1:0] cur_slot;
   logic [US_W-1:0]   slot_width_us;
   logic           out_of_range;
   seq_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.min_width_us  <= US_W'(1000);
         cfg_ff.max_width_us  <= US_W'(2000);
         cfg_ff.sync_width_us <= US_W'(4000);
         cfg_ff.gap_us        <= US_W'(300);
         cfg_ff.ticks_per_us  <= TPU_W'(2);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:        cfg_ff.enable        <= csr_wdata[0];
            CSR_MIN_WIDTH_US:  cfg_ff.min_width_us  <= csr_wdata[US_W-1:0];
            CSR_MAX_WIDTH_US:  cfg_ff.max_width_us  <= csr_wdata[US_W-1:0];
            CSR_SYNC_WIDTH_US: cfg_ff.sync_width_us <= csr_wdata[US_W-1:0];
            CSR_GAP_US:        cfg_ff.gap_us        <= csr_wdata[US_W-1:0];
            CSR_TICKS_PER_US:  cfg_ff.ticks_per_us  <= csr_wdata[TPU_W-1:0];
            default: ;
         endcase
      end
   end

   // The held request moves on whenever the output register is free or drains.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && rsp_valid_ff && rsp_stall;
   assign tick_en   = advance && (req_ff.cmd == CMD_TICK);
   assign write_en  = advance && (req_ff.cmd == CMD_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff.cmd      <= cmd_type'(req_cmd);
         req_ff.channel  <= req_channel;
         req_ff.width_us <= req_width_us;
      end
   end

   rcppm_table u_table (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .wr_en           (write_en),
      .wr_channel      (req_ff.channel),
      .wr_width_us     (req_ff.width_us),
      .rd_slot         (cur_slot),
      .rd_width_us     (slot_width_us),
      .wr_out_of_range (out_of_range)
   );

   rcppm_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .tick_en       (tick_en),
      .slot_width_us (slot_width_us),
      .cur_slot      (cur_slot),
      .status        (status)
   );

   assign rsp_in.line_level    = status.line_level;
   assign rsp_in.slot          = status.slot;
   assign rsp_in.frame_wrap    = status.frame_wrap;
   assign rsp_in.write_ignored = (req_ff.cmd == CMD_WRITE) && out_of_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_level    = rsp_ff.line_level;
   assign rsp_slot          = rsp_ff.slot;
   assign rsp_frame_wrap    = rsp_ff.frame_wrap;
   assign rsp_write_ignored = rsp_ff.write_ignored;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the RC pulse-position frame encoder.
// Drives width writes and timer ticks and compares every response with a local predictor.
// Depends on rcppm_pkg and rc_ppm_frame_encoder.
module testbench;
   import rcppm_pkg::*;

   localparam logic [1:0] PH_GAP  = 2'd0;
   localparam logic [1:0] PH_SLOT = 2'd1;
   localparam int CYCLE_LIMIT      = 100000;
   localparam int LONG_HOLD_AFTER  = 40;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int MAX_REPORTS      = 10;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_cmd = CMD_WRITE;
   logic [SLOT_W-1:0]             req_channel = '0;
   logic signed [REQ_WIDTH_W-1:0] req_width_us = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_line_level;
   logic [SLOT_W-1:0]             rsp_slot;
   logic                          rsp_frame_wrap;
   logic                          rsp_write_ignored;
   logic                          csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   rc_ppm_frame_encoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_channel(req_channel), .req_width_us(req_width_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_line_level(rsp_line_level),
      .rsp_slot(rsp_slot), .rsp_frame_wrap(rsp_frame_wrap),
      .rsp_write_ignored(rsp_write_ignored),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state: configuration copy and sequencer state.
   cfg_type           cfg;
   logic [US_W-1:0]   chan_width_us [NUM_CHANNELS];
   logic [SLOT_W-1:0] slot_idx;
   logic [1:0]        seq_phase;
   logic [TICKS_W-1:0] ticks_left;
   logic              line_hi;

   req_type request_backlog[$];
   rsp_type pending_status[$];
   req_type next_req;
   rsp_type want, got;

   int  queued_count = 0;
   int  accepted_count = 0;
   int  rsp_seen = 0;
   int  fail_count = 0;
   int  writes_sent = 0;
   int  ticks_sent = 0;
   int  wraps_seen = 0;
   int  ignored_seen = 0;
   int  settings_used = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  calm_left = 0;
   bit  long_hold_done = 1'b0;
   bit  no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [TICKS_W-1:0] dur_ticks(input int unsigned us);
      int unsigned t;
      t = us * cfg.ticks_per_us;
      return (t > 32'hFFFF) ? {TICKS_W{1'b1}} : t[TICKS_W-1:0];
   endfunction

   // Applies one request to the predictor state and returns the status it leaves.
   function automatic rsp_type predict_line_status(input req_type r);
      rsp_type o;
      int      w;
      o = '0;
      w = int'($signed(r.width_us));
      if (r.cmd == CMD_WRITE) begin
         if (r.channel >= NUM_CHANNELS) begin
            o.write_ignored = 1'b1;
         end else begin
            if (w > int'(cfg.max_width_us))
               w = int'(cfg.max_width_us);
            else if (w < int'(cfg.min_width_us))
               w = int'(cfg.min_width_us);
            chan_width_us[r.channel[CH_IDX_W-1:0]] = w[US_W-1:0];
         end
      end else if (!cfg.enable) begin
         slot_idx = '0;
         seq_phase = PH_GAP;
         ticks_left = '0;
         line_hi = 1'b0;
      end else if (ticks_left > 1) begin
         ticks_left--;
      end else if (seq_phase == PH_SLOT) begin
         // The line goes high for the gap unless the sync slot just ended.
         ticks_left = dur_ticks(int'(cfg.gap_us));
         line_hi = (slot_idx < NUM_CHANNELS);
         seq_phase = PH_GAP;
         slot_idx++;
         if (slot_idx > NUM_CHANNELS) begin
            slot_idx = '0;
            o.frame_wrap = 1'b1;
         end
      end else begin
         ticks_left = dur_ticks(slot_idx < NUM_CHANNELS
                                ? int'(chan_width_us[slot_idx[CH_IDX_W-1:0]])
                                : int'(cfg.sync_width_us));
         line_hi = 1'b0;
         seq_phase = PH_SLOT;
      end
      o.line_level = line_hi;
      o.slot = slot_idx;
      return o;
   endfunction

   function automatic req_type random_request(input int tick_pct);
      req_type r;
      r.cmd = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_WRITE;
      if ($urandom_range(0, 4) == 0)
         r.channel = SLOT_W'($urandom_range(NUM_CHANNELS, 15));
      else
         r.channel = SLOT_W'($urandom_range(0, NUM_CHANNELS - 1));
      case ($urandom_range(0, 3))
         0: r.width_us = REQ_WIDTH_W'($urandom);
         1: r.width_us = REQ_WIDTH_W'($urandom_range(0, 4095));
         default: r.width_us = REQ_WIDTH_W'($urandom_range(0, 8));
      endcase
      return r;
   endfunction

   task automatic queue_request(input cmd_type cmd, input int ch, input int w);
      req_type r;
      r.cmd = cmd;
      r.channel = SLOT_W'(ch);
      r.width_us = REQ_WIDTH_W'(w);
      request_backlog.push_back(r);
      queued_count++;
   endtask

   task automatic queue_random(input int count, input int tick_pct);
      repeat (count) begin
         request_backlog.push_back(random_request(tick_pct));
         queued_count++;
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      case (idx)
         CSR_ENABLE:        cfg.enable = val[0];
         CSR_MIN_WIDTH_US:  cfg.min_width_us = val[US_W-1:0];
         CSR_MAX_WIDTH_US:  cfg.max_width_us = val[US_W-1:0];
         CSR_SYNC_WIDTH_US: cfg.sync_width_us = val[US_W-1:0];
         CSR_GAP_US:        cfg.gap_us = val[US_W-1:0];
         CSR_TICKS_PER_US:  cfg.ticks_per_us = val[TPU_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int unsigned en, input int unsigned mn,
                                 input int unsigned mx, input int unsigned sy,
                                 input int unsigned gp, input int unsigned tpu);
      write_reg(CSR_ENABLE, en);
      write_reg(CSR_MIN_WIDTH_US, mn);
      write_reg(CSR_MAX_WIDTH_US, mx);
      write_reg(CSR_SYNC_WIDTH_US, sy);
      write_reg(CSR_GAP_US, gp);
      write_reg(CSR_TICKS_PER_US, tpu);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Waits until every queued request has been accepted and answered.
   task automatic drain();
      do @(posedge clock);
      while (accepted_count != queued_count || pending_status.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      cfg.enable = 1'b0;
      cfg.min_width_us = 1000;
      cfg.max_width_us = 2000;
      cfg.sync_width_us = 4000;
      cfg.gap_us = 300;
      cfg.ticks_per_us = 2;
      for (int k = 0; k < NUM_CHANNELS; k++)
         chan_width_us[k] = DEFAULT_WIDTH_US;
      slot_idx = '0;
      seq_phase = PH_GAP;
      ticks_left = '0;
      line_hi = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, generator idle: clamping extremes and ignored writes.
      queue_request(CMD_WRITE, 0, -32768);
      queue_request(CMD_WRITE, 1, 32767);
      queue_request(CMD_WRITE, 2, 0);
      queue_request(CMD_WRITE, 3, 1500);
      queue_request(CMD_WRITE, 7, 2001);
      queue_request(CMD_WRITE, 8, 100);
      queue_request(CMD_WRITE, 15, -1);
      queue_request(CMD_TICK, 0, 0);
      queue_request(CMD_TICK, 0, 0);
      drain();

      // Short slots so that many whole frames play out.
      apply_settings(1, 0, 6, 3, 1, 1);
      queue_random(150, 75);
      drain();

      // Crossed clamps with zero-length gaps and sync slot.
      apply_settings(1, 5, 2, 0, 0, 2);
      queue_request(CMD_WRITE, 0, 10);
      queue_request(CMD_WRITE, 1, 3);
      queue_request(CMD_WRITE, 2, -4);
      queue_request(CMD_WRITE, 3, 0);
      queue_random(80, 70);
      drain();

      // Zero ticks per microsecond: every phase lasts a single tick.
      apply_settings(1, 0, 4095, 4095, 4095, 0);
      queue_random(50, 80);
      drain();

      // Widest settings, then an oversized tick rate that saturates durations.
      apply_settings(1, 0, 4095, 4095, 4095, 16);
      queue_request(CMD_WRITE, 0, 0);
      queue_request(CMD_WRITE, 1, 4095);
      queue_request(CMD_TICK, 0, 0);
      queue_request(CMD_TICK, 0, 0);
      queue_request(CMD_TICK, 0, 0);
      queue_random(20, 50);
      drain();
      apply_settings(0, 0, 4095, 4095, 4095, 31);
      queue_request(CMD_TICK, 0, 0);
      drain();
      apply_settings(1, 0, 4095, 4095, 4095, 31);
      queue_request(CMD_TICK, 0, 0);
      queue_request(CMD_TICK, 0, 0);
      queue_request(CMD_TICK, 0, 0);
      queue_random(10, 60);
      drain();

      // Final stretch at full rate on both sides.
      apply_settings(1, 1, 4, 6, 2, 2);
      no_idle = 1'b1;
      queue_random(120, 80);
      drain();
      repeat (4) @(posedge clock);

      if (pending_status.size() != 0)
         fail_count++;
      $display("Run covered %0d requests (%0d writes, %0d ticks) over %0d register settings.",
               accepted_count, writes_sent, ticks_sent, settings_used);
      $display("Observed %0d frame wraps and %0d ignored channel writes.",
               wraps_seen, ignored_seen);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Request driver: the payload only changes once the current request is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_status.push_back(predict_line_status({req_cmd, req_channel, req_width_us}));
            accepted_count++;
            if (req_cmd == CMD_TICK)
               ticks_sent++;
            else
               writes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               next_req = request_backlog.pop_front();
               req_cmd <= next_req.cmd;
               req_channel <= next_req.channel;
               req_width_us <= next_req.width_us;
               req_valid <= 1'b1;
               if (!no_idle && $urandom_range(0, 4) == 0)
                  send_gap = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure, with one long hold to fill the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!long_hold_done && rsp_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && calm_left == 0 && !no_idle) begin
            if ($urandom_range(0, 2) == 0)
               stall_left = $urandom_range(1, 9);
            else
               calm_left = $urandom_range(1, 30);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (calm_left > 0)
               calm_left--;
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         got = {rsp_line_level, rsp_slot, rsp_frame_wrap, rsp_write_ignored};
         if (pending_status.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("Response %0d arrived with no request waiting: line=%0d slot=%0d",
                        rsp_seen, got.line_level, got.slot);
         end else begin
            want = pending_status.pop_front();
            if (want.frame_wrap)
               wraps_seen++;
            if (want.write_ignored)
               ignored_seen++;
            if (got.line_level !== want.line_level || got.slot !== want.slot ||
                got.frame_wrap !== want.frame_wrap ||
                got.write_ignored !== want.write_ignored) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("Mismatch on response %0d: expected line=%0d slot=%0d wrap=%0d ignored=%0d",
                           rsp_seen, want.line_level, want.slot, want.frame_wrap,
                           want.write_ignored);
                  $display("   got line=%0d slot=%0d wrap=%0d ignored=%0d",
                           got.line_level, got.slot, got.frame_wrap, got.write_ignored);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_status.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
